@@ rtl/core/tmps_pkg.sv @@
// Shared types, constants and arithmetic helpers for the touch marker pixel shader.
package tmps_pkg;

    localparam logic [2:0]  DENSITY_MIN   = 3'd1;
    localparam logic [2:0]  DENSITY_MAX   = 3'd4;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int          SQRT_STEPS    = 12;
    localparam logic [1:0]  STYLE_DISC    = 2'd0;
    localparam logic [1:0]  STYLE_CORE    = 2'd1;
    localparam logic [23:0] INK_YELLOW    = 24'hFFDD33;
    localparam logic [23:0] INK_RED       = 24'hE02020;
    localparam logic [18:0] RECIP_255     = 19'd263173;
    localparam int          RECIP_SHIFT   = 26;

    typedef struct packed {
        logic [1:0] style;
        logic       colour;
        logic [2:0] frame;
        logic [2:0] dens;
    } meta_t;

    typedef struct packed {
        logic [10:0] adx;
        logic [10:0] ady;
        meta_t       meta;
    } item_t;

    // Animation time 0..255 for each frame.
    function automatic logic [7:0] t_of(input logic [2:0] frame);
        logic [7:0] t;
        case (frame)
            3'd0:    t = 8'd0;
            3'd1:    t = 8'd36;
            3'd2:    t = 8'd72;
            3'd3:    t = 8'd109;
            3'd4:    t = 8'd145;
            3'd5:    t = 8'd182;
            3'd6:    t = 8'd218;
            default: t = 8'd255;
        endcase
        return t;
    endfunction

    // Quadratic fade factor for each frame.
    function automatic logic [7:0] fade_of(input logic [2:0] frame);
        logic [7:0] f;
        case (frame)
            3'd0:    f = 8'd255;
            3'd1:    f = 8'd250;
            3'd2:    f = 8'd235;
            3'd3:    f = 8'd209;
            3'd4:    f = 8'd173;
            3'd5:    f = 8'd126;
            3'd6:    f = 8'd69;
            default: f = 8'd0;
        endcase
        return f;
    endfunction

    // Exact floor(v / 255) for v below 261120.
    function automatic logic [9:0] div255(input logic [17:0] v);
        logic [36:0] p;
        p = 37'(v) * 37'(RECIP_255);
        return 10'(p >> RECIP_SHIFT);
    endfunction

    // ceil(2^16 / m) for the ramp widths in halves of a pixel.
    function automatic logic [15:0] recip_of(input logic [3:0] m);
        logic [15:0] r;
        case (m)
            4'd2:    r = 16'd32768;
            4'd3:    r = 16'd21846;
            4'd4:    r = 16'd16384;
            4'd6:    r = 16'd10923;
            4'd8:    r = 16'd8192;
            4'd9:    r = 16'd7282;
            4'd12:   r = 16'd5462;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/tmps_front.sv @@
// Front end: density register, clamping and centre offsets of each pixel word.
module tmps_front
    import tmps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic [6:0]  pixel_x,
    input  logic [6:0]  pixel_y,
    input  logic [1:0]  style,
    input  logic        colour,
    input  logic [2:0]  frame_number,
    output item_t       item
);

    logic [2:0]  density_reg;
    logic [2:0]  dens;
    logic [10:0] centre;
    logic [11:0] dx;
    logic [11:0] dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_reg <= DENSITY_MIN;
        end
        else if (cfg_wr_en)
        begin
            density_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (density_reg < DENSITY_MIN)
        begin
            dens = DENSITY_MIN;
        end
        else if (density_reg > DENSITY_MAX)
        begin
            dens = DENSITY_MAX;
        end
        else
        begin
            dens = density_reg;
        end
        // centre = (side - 1) * 8 with side = 32 * dens
        centre = {dens, 8'd0} - 11'd8;
        dx = {1'b0, pixel_x, 4'd0} - {1'b0, centre};
        dy = {1'b0, pixel_y, 4'd0} - {1'b0, centre};
        item.adx = dx[11] ? 11'(-dx) : dx[10:0];
        item.ady = dy[11] ? 11'(-dy) : dy[10:0];
        item.meta.style  = style;
        item.meta.colour = colour;
        item.meta.frame  = frame_number;
        item.meta.dens   = dens;
    end

endmodule

@@ rtl/core/tmps_queue.sv @@
// Short queue between the front end and the shading pipeline.
module tmps_queue
    import tmps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    input  logic  pop,
    output item_t rdata,
    output logic  full,
    output logic  empty
);

    item_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

endmodule

@@ rtl/core/tmps_back.sv @@
// Shading pipeline: distance square root, alpha ramps, fade and output register.
module tmps_back
    import tmps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] argb
);

    typedef struct packed {
        logic        valid;
        meta_t       meta;
        logic [22:0] n;
        logic [17:0] v;
    } s0_t;

    typedef struct packed {
        logic        valid;
        meta_t       meta;
        logic [22:0] n;
        logic [23:0] r;
        logic [11:0] rad;
    } sq_t;

    typedef struct packed {
        logic        full;
        logic        zero;
        logic [11:0] np;
        logic [3:0]  m;
    } ramp_t;

    typedef struct packed {
        logic  valid;
        meta_t meta;
        ramp_t ra;
        ramp_t rb;
        ramp_t rc;
    } r1_t;

    typedef struct packed {
        logic       valid;
        meta_t      meta;
        logic [8:0] aa;
        logic [8:0] ab;
        logic [8:0] ac;
    } r2_t;

    typedef struct packed {
        logic        valid;
        logic        colour;
        logic [15:0] prod;
    } r3_t;

    s0_t  s0_reg,  s0_next;
    sq_t  sq_reg [SQRT_STEPS+1];
    sq_t  sq_next [SQRT_STEPS+1];
    r1_t  r1_reg,  r1_next;
    r2_t  r2_reg,  r2_next;
    r3_t  r3_reg,  r3_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] argb_reg, argb_next;
    logic        en;

    function automatic sq_t sqrt_step(input sq_t s, input int i);
        logic [23:0] bitv;
        logic [23:0] trial;
        sq_t         o;
        bitv  = 24'(1) << (22 - 2 * i);
        trial = s.r + bitv;
        o = s;
        if ({1'b0, s.n} >= trial)
        begin
            o.n = 23'({1'b0, s.n} - trial);
            o.r = (s.r >> 1) + bitv;
        end
        else
        begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic ramp_t ramp_prep(input logic [11:0] d, input logic [11:0] inner,
                                        input logic [3:0] m);
        logic [12:0] outer;
        logic [11:0] diff;
        logic [19:0] scaled;
        ramp_t       o;
        outer    = {1'b0, inner} + {6'd0, m, 3'd0};
        diff     = d - inner;
        scaled   = 20'(diff) * 20'd255;
        o.full   = (d <= inner);
        o.zero   = ({1'b0, d} >= outer);
        o.np     = 12'(scaled >> 3);
        o.m      = m;
        return o;
    endfunction

    function automatic logic [8:0] ramp_alpha(input ramp_t r);
        logic [27:0] p;
        logic [7:0]  q;
        p = 28'(r.np) * 28'(recip_of(r.m));
        q = 8'(p >> 16);
        if (r.full)
        begin
            return 9'd255;
        end
        else if (r.zero)
        begin
            return 9'd0;
        end
        return 9'd255 - {1'b0, q};
    endfunction

    // Advance the whole pipeline unless the output word is held.
    assign en  = !(out_valid_reg && out_stall);
    assign pop = en && !empty;

    always_comb
    begin
        logic [10:0] td;
        logic [5:0]  base_mul;
        logic [11:0] d;
        logic [11:0] dm;
        logic [3:0]  m2;
        logic [3:0]  m3;
        logic signed [9:0] a;
        logic signed [9:0] ring;
        logic [9:0]  alpha_q;

        // Stage 0: squared distance and radius growth product.
        td = 11'(t_of(item.meta.frame)) * 11'(item.meta.dens);
        s0_next.valid = pop;
        s0_next.meta  = item.meta;
        s0_next.n     = 23'(22'(item.adx) * 22'(item.adx)) + 23'(22'(item.ady) * 22'(item.ady));
        s0_next.v     = (item.meta.style == STYLE_DISC) ? 18'(td) * 18'd160 : 18'(td) * 18'd192;

        // Stage 1: radius, start the root.
        base_mul = (s0_reg.meta.style == STYLE_DISC) ? 6'd48 : 6'd32;
        sq_next[0].valid = s0_reg.valid;
        sq_next[0].meta  = s0_reg.meta;
        sq_next[0].n     = s0_reg.n;
        sq_next[0].r     = '0;
        sq_next[0].rad   = 12'(base_mul) * 12'(s0_reg.meta.dens) + 12'(div255(s0_reg.v));

        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            sq_next[i+1] = sqrt_step(sq_reg[i], i);
        end

        // Ramp set-up: widths are 8*m sixteenths.
        d  = sq_reg[SQRT_STEPS].r[11:0];
        dm = 12'(sq_reg[SQRT_STEPS].meta.dens);
        m2 = {dm[2:0], 1'b0};
        m3 = 4'(dm * 12'd3);
        r1_next.valid = sq_reg[SQRT_STEPS].valid;
        r1_next.meta  = sq_reg[SQRT_STEPS].meta;
        case (sq_reg[SQRT_STEPS].meta.style)
            STYLE_DISC:
            begin
                r1_next.ra = ramp_prep(d, sq_reg[SQRT_STEPS].rad - dm * 12'd24, m3);
                r1_next.rb = ramp_prep(d, '0, m2);
                r1_next.rc = ramp_prep(d, '0, m2);
            end
            STYLE_CORE:
            begin
                r1_next.ra = ramp_prep(d, dm * 12'd48, m2);
                r1_next.rb = ramp_prep(d, dm * 12'd128, m2);
                r1_next.rc = ramp_prep(d, dm * 12'd96, m2);
            end
            default:
            begin
                r1_next.ra = ramp_prep(d, sq_reg[SQRT_STEPS].rad, m2);
                r1_next.rb = ramp_prep(d, sq_reg[SQRT_STEPS].rad - dm * 12'd32, m2);
                r1_next.rc = ramp_prep(d, '0, m2);
            end
        endcase

        r2_next.valid = r1_reg.valid;
        r2_next.meta  = r1_reg.meta;
        r2_next.aa    = ramp_alpha(r1_reg.ra);
        r2_next.ab    = ramp_alpha(r1_reg.rb);
        r2_next.ac    = ramp_alpha(r1_reg.rc);

        // Combine the ramps, then scale by the fade.
        ring = '0;
        case (r2_reg.meta.style)
            STYLE_DISC:
            begin
                a = signed'({1'b0, r2_reg.aa});
            end
            STYLE_CORE:
            begin
                ring = signed'({1'b0, r2_reg.ab}) - signed'({1'b0, r2_reg.ac});
                a = (signed'({1'b0, r2_reg.aa}) > ring) ? signed'({1'b0, r2_reg.aa}) :
                    ((ring > 0) ? ring : '0);
            end
            default:
            begin
                ring = signed'({1'b0, r2_reg.aa}) - signed'({1'b0, r2_reg.ab});
                a = (ring > 0) ? ring : '0;
            end
        endcase
        r3_next.valid  = r2_reg.valid;
        r3_next.colour = r2_reg.meta.colour;
        r3_next.prod   = 16'(a[7:0]) * 16'(fade_of(r2_reg.meta.frame));

        out_valid_next = r3_reg.valid;
        alpha_q        = div255({2'd0, r3_reg.prod});
        argb_next      = {alpha_q[7:0], r3_reg.colour ? INK_RED : INK_YELLOW};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg        <= '0;
            r1_reg        <= '0;
            r2_reg        <= '0;
            r3_reg        <= '0;
            out_valid_reg <= 1'b0;
            argb_reg      <= '0;
            for (int i = 0; i <= SQRT_STEPS; i++)
            begin
                sq_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            s0_reg        <= s0_next;
            r1_reg        <= r1_next;
            r2_reg        <= r2_next;
            r3_reg        <= r3_next;
            out_valid_reg <= out_valid_next;
            argb_reg      <= argb_next;
            for (int i = 0; i <= SQRT_STEPS; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign argb      = argb_reg;

endmodule

@@ rtl/core/touch_marker_pixel_shader_unit.sv @@
// Top level of the touch marker pixel shader.
//
// Input channel: in_valid / in_stall with pixel_x, pixel_y, style, colour and
// frame_number; a word is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with argb, alpha in bits 31..24.
// Configuration: cfg_wr_en writes cfg_wr_data into the density register.
//
// One pixel enters and one leaves per clock unless out_stall holds the output word.
// From acceptance to out_valid a word passes two set-up stages, twelve square root
// stages (one result bit each), three ramp and fade stages and the output register;
// an empty queue hands the word on in the cycle after it is taken, unless stalled.
// The square root pipeline sets the depth.
// When out_stall holds the output word, the pipeline freezes and the four-entry
// queue absorbs new pixels; in_stall rises once the queue is full.
// Reset clears the pipeline and queue, and sets density to 1.
module touch_marker_pixel_shader_unit
    import tmps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [6:0]  pixel_x,
    input  logic [6:0]  pixel_y,
    input  logic [1:0]  style,
    input  logic        colour,
    input  logic [2:0]  frame_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] argb
);

    item_t front_item;
    item_t queue_item;
    logic  full;
    logic  empty;
    logic  pop;

    tmps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .style        (style),
        .colour       (colour),
        .frame_number (frame_number),
        .item         (front_item)
    );

    tmps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_valid && !full),
        .wdata (front_item),
        .pop   (pop),
        .rdata (queue_item),
        .full  (full),
        .empty (empty)
    );

    tmps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (queue_item),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .argb      (argb)
    );

    assign in_stall = full;

endmodule

@@ rtl/core/tmps_checker.sv @@
// Port-level checks for the touch marker pixel shader, bound to the top level.
module tmps_checker
    import tmps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] argb
);

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(argb))
        else $error("output word changed while stalled");

    a_colour: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (argb[23:0] == INK_YELLOW) || (argb[23:0] == INK_RED))
        else $error("colour field is not one of the two inks");

    // The queue can only fill while the output side holds a word.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind touch_marker_pixel_shader_unit tmps_checker u_tmps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .argb      (argb)
);

@@ bench/tb_top.sv @@
// Self-checking testbench for the touch marker pixel shader unit.
`timescale 1ns / 1ps

module tb_top
    import tmps_pkg::*;
();

    localparam int ITEM_COUNT = 1250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [6:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic [1:0]  style;
    logic        colour;
    logic [2:0]  frame_number;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] argb;

    typedef struct {
        logic [6:0] px;
        logic [6:0] py;
        logic [1:0] sty;
        logic       ink;
        logic [2:0] frm;
        logic       known;
        logic [31:0] argb_known;
    } pixel_row_t;

    logic [31:0] pending_argb[$];
    logic [2:0]  density_reg;
    int          error_count;
    int          cycle_count;
    int          hold_cycles;

    touch_marker_pixel_shader_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .style        (style),
        .colour       (colour),
        .frame_number (frame_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .argb         (argb)
    );

    always #5 clk = ~clk;

    function automatic int scale_len(input int sixteenths, input int side);
        return (sixteenths * side) / 32;
    endfunction

    function automatic int soft_edge(input int d, input int inner, input int outer);
        if (outer <= inner)
            return d <= inner ? 255 : 0;
        if (d <= inner)
            return 255;
        if (d >= outer)
            return 0;
        return 255 - (255 * (d - inner)) / (outer - inner);
    endfunction

    function automatic int radius16(input int x, input int y, input int side);
        int          mid;
        int          dx;
        int          dy;
        logic [31:0] n;
        logic [31:0] r;
        logic [31:0] b;
        mid = (side - 1) * 8;
        dx = x * 16 - mid;
        dy = y * 16 - mid;
        n = 32'(dx * dx) + 32'(dy * dy);
        r = 0;
        b = 32'd1 << 30;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return int'(r);
    endfunction

    function automatic logic [31:0] shade_pixel(input logic [6:0] px, input logic [6:0] py,
                                                input logic [1:0] sty, input logic ink,
                                                input logic [2:0] frm, input logic [2:0] dens);
        int dn;
        int side;
        int t;
        int fade;
        int d;
        int a;
        int r;
        int core;
        int ring;
        dn = dens;
        if (dn < 1)
            dn = 1;
        if (dn > 4)
            dn = 4;
        side = 32 * dn;
        t = (int'(frm) * 255) / 7;
        fade = 255 - (t * t) / 255;
        d = radius16(px, py, side);
        if (sty == STYLE_DISC)
        begin
            r = scale_len(48, side) + (t * scale_len(160, side)) / 255;
            a = soft_edge(d, r - scale_len(24, side), r);
        end
        else if (sty == STYLE_CORE)
        begin
            core = soft_edge(d, scale_len(48, side), scale_len(64, side));
            ring = soft_edge(d, scale_len(128, side), scale_len(144, side))
                   - soft_edge(d, scale_len(96, side), scale_len(112, side));
            a = core > ring ? core : (ring > 0 ? ring : 0);
        end
        else
        begin
            r = scale_len(32, side) + (t * scale_len(192, side)) / 255;
            a = soft_edge(d, r, r + scale_len(16, side))
                - soft_edge(d, r - scale_len(32, side), r - scale_len(16, side));
            if (a < 0)
                a = 0;
        end
        a = (a * fade) / 255;
        if (a < 0)
            a = 0;
        if (a > 255)
            a = 255;
        return {8'(a), ink ? INK_RED : INK_YELLOW};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %08h want %08h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Offer one word and hold it until taken; drop valid only across an idle gap.
    task automatic send_pixel(input pixel_row_t row);
        logic [31:0] want;
        int gap;
        gap = 0;
        want = shade_pixel(row.px, row.py, row.sty, row.ink, row.frm, density_reg);
        if (row.known && want != row.argb_known)
            report_mismatch("table", want, row.argb_known);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= row.px;
        pixel_y <= row.py;
        style <= row.sty;
        colour <= row.ink;
        frame_number <= row.frm;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_argb.push_back(row.known ? row.argb_known : want);
    endtask

    task automatic write_density(input logic [2:0] value);
        in_valid <= 1'b0;
        while (pending_argb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        density_reg = value;
    endtask

    function automatic pixel_row_t make_row(input int x, input int y, input int s,
                                            input int c, input int f);
        pixel_row_t row;
        row.px = 7'(x);
        row.py = 7'(y);
        row.sty = 2'(s);
        row.ink = 1'(c);
        row.frm = 3'(f);
        row.known = 1'b0;
        row.argb_known = '0;
        return row;
    endfunction

    // Receiver: random stalls, one long hold-off in the middle of the run.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_argb.size() == 0)
                report_mismatch("unexpected word", argb, 32'h0);
            else
            begin
                if (argb[31:24] != pending_argb[0][31:24])
                    report_mismatch("alpha", argb, pending_argb[0]);
                if (argb[23:0] != pending_argb[0][23:0])
                    report_mismatch("colour", argb, pending_argb[0]);
                void'(pending_argb.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        pixel_row_t table_rows[$];
        pixel_row_t row;
        logic [2:0] dens_plan[6];
        int side;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        style = '0;
        colour = '0;
        frame_number = '0;
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        density_reg = 3'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Last frame fades to zero alpha; colour bits are fixed.
        row = make_row(0, 0, 0, 0, 7);
        row.known = 1'b1; row.argb_known = {8'h00, INK_YELLOW};
        table_rows.push_back(row);
        row = make_row(127, 127, 1, 1, 7);
        row.known = 1'b1; row.argb_known = {8'h00, INK_RED};
        table_rows.push_back(row);
        // Far corner of a 32 pixel frame is outside every shape at frame 0.
        row = make_row(0, 0, 0, 1, 0);
        row.known = 1'b1; row.argb_known = {8'h00, INK_RED};
        table_rows.push_back(row);
        // Centre at frame 0: full disc and full core.
        row = make_row(15, 15, 0, 0, 0);
        row.known = 1'b1; row.argb_known = {8'hFF, INK_YELLOW};
        table_rows.push_back(row);
        row = make_row(16, 16, 1, 1, 0);
        row.known = 1'b1; row.argb_known = {8'hFF, INK_RED};
        table_rows.push_back(row);
        for (int s = 0; s < 4; s++)
            for (int f = 0; f < 8; f += 3)
                table_rows.push_back(make_row(16 + s, 12, s, s & 1, f));
        table_rows.push_back(make_row(127, 0, 2, 0, 1));
        table_rows.push_back(make_row(0, 127, 3, 1, 2));
        table_rows.push_back(make_row(85, 42, 1, 0, 5));
        table_rows.push_back(make_row(42, 85, 0, 1, 6));
        foreach (table_rows[i])
            send_pixel(table_rows[i]);

        dens_plan = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1};
        for (int p = 0; p < 6; p++)
        begin
            write_density(dens_plan[p]);
            side = 32 * ((dens_plan[p] == 0) ? 1 : (dens_plan[p] > 4 ? 4 : dens_plan[p]));
            for (int k = 0; k < ITEM_COUNT / 6; k++)
            begin
                if (p == 2 && k == 30)
                    hold_cycles = 120;
                if ($urandom_range(0, 9) == 0)
                    row = make_row($urandom_range(0, 127), $urandom_range(0, 127),
                                   $urandom_range(0, 3), $urandom_range(0, 1),
                                   $urandom_range(0, 7));
                else
                    row = make_row($urandom_range(0, side - 1), $urandom_range(0, side - 1),
                                   $urandom_range(0, 3), $urandom_range(0, 1),
                                   $urandom_range(0, 7));
                send_pixel(row);
            end
        end
        in_valid <= 1'b0;
        while (pending_argb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
